// ===== rtl/spq_pkg.sv =====
// Shared constants, codes and controller/datapath interface types for the sorted priority queue.
package spq_pkg;

    localparam int DEPTH  = 64;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int DATA_W = 32;
    localparam int STAT_W = 2;
    localparam int FILL_W = 7;
    localparam int OP_W   = 1;
    localparam int OUT_TDATA_W = ((DATA_W + FILL_W + 7) / 8) * 8;
    localparam int OUT_PAD_W   = OUT_TDATA_W - DATA_W - FILL_W;

    localparam logic [OP_W-1:0] OP_INSERT = 1'b0;
    localparam logic [OP_W-1:0] OP_REMOVE = 1'b1;

    localparam logic [STAT_W-1:0] ST_OK       = 2'd0;
    localparam logic [STAT_W-1:0] ST_OVERFLOW = 2'd1;
    localparam logic [STAT_W-1:0] ST_EMPTY    = 2'd2;

    typedef struct packed {
        logic              load;
        logic [STAT_W-1:0] res_status;
        logic              rd_en;
        logic              rd_head;
        logic              wr_shift;
        logic              wr_key;
        logic              idx_dec;
        logic              cnt_inc;
        logic              cnt_dec;
        logic              head_inc;
        logic              res_from_mem;
        logic              out_load;
    } spq_cmd_t;

    typedef struct packed {
        logic in_op;
        logic full;
        logic empty;
        logic mem_le;
        logic idx_one;
        logic out_free;
    } spq_sts_t;

endpackage

// ===== rtl/spq_ctrl.sv =====
// Sequencing state machine for the sorted priority queue.
module spq_ctrl
    import spq_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     s_tvalid,
    output logic     s_tready,
    input  spq_sts_t sts,
    output spq_cmd_t cmd
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_READ  = 3'd1;
    localparam logic [2:0] S_CMP   = 3'd2;
    localparam logic [2:0] S_WKEY  = 3'd3;
    localparam logic [2:0] S_RHEAD = 3'd4;
    localparam logic [2:0] S_RTAKE = 3'd5;
    localparam logic [2:0] S_FIN   = 3'd6;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        s_tready   = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.load = 1'b1;
                    if (sts.in_op == OP_INSERT)
                    begin
                        priority if (sts.full)
                        begin
                            cmd.res_status = ST_OVERFLOW;
                            state_next     = S_FIN;
                        end
                        else if (sts.empty)
                        begin
                            state_next = S_WKEY;
                        end
                        else
                        begin
                            state_next = S_READ;
                        end
                    end
                    else
                    begin
                        if (sts.empty)
                        begin
                            cmd.res_status = ST_EMPTY;
                            state_next     = S_FIN;
                        end
                        else
                        begin
                            state_next = S_RHEAD;
                        end
                    end
                end
            end
            S_READ:
            begin
                cmd.rd_en  = 1'b1;
                state_next = S_CMP;
            end
            S_CMP:
            begin
                if (sts.mem_le)
                begin
                    cmd.wr_shift = 1'b1;
                    cmd.idx_dec  = 1'b1;
                    state_next   = sts.idx_one ? S_WKEY : S_READ;
                end
                else
                begin
                    state_next = S_WKEY;
                end
            end
            S_WKEY:
            begin
                cmd.wr_key  = 1'b1;
                cmd.cnt_inc = 1'b1;
                state_next  = S_FIN;
            end
            S_RHEAD:
            begin
                cmd.rd_en   = 1'b1;
                cmd.rd_head = 1'b1;
                state_next  = S_RTAKE;
            end
            S_RTAKE:
            begin
                cmd.res_from_mem = 1'b1;
                cmd.head_inc     = 1'b1;
                cmd.cnt_dec      = 1'b1;
                state_next       = S_FIN;
            end
            S_FIN:
            begin
                if (sts.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

// ===== rtl/spq_dpath.sv =====
// Datapath of the sorted priority queue: entry memory, pointers, compare and output register.
module spq_dpath
    import spq_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic [OP_W-1:0]        s_tuser,
    input  logic [DATA_W-1:0]      s_tdata,
    input  logic                   m_tready,
    output logic                   m_tvalid,
    output logic [OUT_TDATA_W-1:0] m_tdata,
    output logic [STAT_W-1:0]      m_tuser,
    input  spq_cmd_t               cmd,
    output spq_sts_t               sts
);

    // Entries are held in a ring: logical slot i lives at head + i.
    logic [DATA_W-1:0] mem [DEPTH];

    logic [ADDR_W-1:0]        head_reg;
    logic [CNT_W-1:0]         count_reg;
    logic [CNT_W-1:0]         idx_reg;
    logic signed [DATA_W-1:0] key_reg;
    logic signed [DATA_W-1:0] rd_data_reg;
    logic [DATA_W-1:0]        res_value_reg;
    logic [STAT_W-1:0]        res_status_reg;
    logic                     out_valid_reg;
    logic [DATA_W-1:0]        out_value_reg;
    logic [STAT_W-1:0]        out_status_reg;
    logic [FILL_W-1:0]        out_fill_reg;

    logic [CNT_W-1:0]  idx_prev;
    logic [ADDR_W-1:0] wr_addr;
    logic [ADDR_W-1:0] rd_addr;
    logic [DATA_W-1:0] wr_data;

    function automatic logic [ADDR_W-1:0] ring_addr(input logic [ADDR_W-1:0] base,
                                                    input logic [ADDR_W-1:0] off);
        logic [ADDR_W:0] sum;
        sum = {1'b0, base} + {1'b0, off};
        if (sum >= (ADDR_W+1)'(DEPTH))
        begin
            sum = sum - (ADDR_W+1)'(DEPTH);
        end
        return sum[ADDR_W-1:0];
    endfunction

    assign idx_prev = idx_reg - CNT_W'(1);
    assign wr_addr  = ring_addr(head_reg, idx_reg[ADDR_W-1:0]);
    assign rd_addr  = cmd.rd_head ? head_reg : ring_addr(head_reg, idx_prev[ADDR_W-1:0]);
    assign wr_data  = cmd.wr_key ? key_reg : rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.wr_shift || cmd.wr_key)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (cmd.rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg      <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.head_inc)
            begin
                head_reg <= (head_reg == ADDR_W'(DEPTH - 1)) ? '0 : head_reg + ADDR_W'(1);
            end
            if (cmd.cnt_inc)
            begin
                count_reg <= count_reg + CNT_W'(1);
            end
            else if (cmd.cnt_dec)
            begin
                count_reg <= count_reg - CNT_W'(1);
            end
            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            key_reg        <= s_tdata;
            idx_reg        <= count_reg;
            res_value_reg  <= '0;
            res_status_reg <= cmd.res_status;
        end
        else
        begin
            if (cmd.idx_dec)
            begin
                idx_reg <= idx_prev;
            end
            if (cmd.res_from_mem)
            begin
                res_value_reg <= rd_data_reg;
            end
        end
        if (cmd.out_load)
        begin
            out_value_reg  <= res_value_reg;
            out_status_reg <= res_status_reg;
            out_fill_reg   <= FILL_W'(count_reg);
        end
    end

    assign sts.in_op    = s_tuser[0];
    assign sts.full     = (count_reg == CNT_W'(DEPTH));
    assign sts.empty    = (count_reg == '0);
    assign sts.mem_le   = (rd_data_reg <= key_reg);
    assign sts.idx_one  = (idx_reg == CNT_W'(1));
    assign sts.out_free = !out_valid_reg || m_tready;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{OUT_PAD_W{1'b0}}, out_fill_reg, out_value_reg};
    assign m_tuser  = out_status_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("fill count beyond depth");

    a_head_bound: assert property (@(posedge clk) disable iff (!rst_n)
        head_reg <= ADDR_W'(DEPTH - 1))
        else $error("head pointer out of range");

    a_inc_not_full: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.cnt_inc |-> (count_reg != CNT_W'(DEPTH)))
        else $error("insert committed on a full queue");

    a_dec_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.cnt_dec |-> (count_reg != '0))
        else $error("remove committed on an empty queue");

    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (out_status_reg != ST_OK)) |-> (out_value_reg == '0))
        else $error("refused operation returned a non-zero value");

endmodule

// ===== rtl/sorted_priority_queue_unit.sv =====
// Top level of the bounded sorted priority queue: controller and datapath.
//
//  Group  Direction  Word contents (lowest bit first)
//  s_*    in         tdata: value[31:0];  tuser: op[0] (0 insert, 1 remove largest)
//  m_*    out        tdata: removed_value[31:0], fill_count[38:32], zero pad[39];
//                    tuser: status[1:0] (0 ok, 1 overflow, 2 empty)
//
// Entries sit in a single-port ring memory with a registered read, descending
// from the head. An insert walks back from the tail, moving one entry a slot
// down per read/compare pair until it meets a larger entry or reaches the
// head, then writes the key. A remove only advances the head pointer; a
// refused insert or remove goes straight to the result.
// Reset (rst_n low, asynchronous) empties the queue and drops any pending
// result; memory contents are left as they are.
// A finished result waits in the output register while the next word is
// accepted; the controller only stalls if a second result is ready first.
module sorted_priority_queue_unit
    import spq_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [DATA_W-1:0]      s_tdata,   // value[31:0]
    input  logic [OP_W-1:0]        s_tuser,   // op[0]
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [OUT_TDATA_W-1:0] m_tdata,   // removed_value[31:0], fill_count[38:32], pad
    output logic [STAT_W-1:0]      m_tuser    // status[1:0]
);

    spq_cmd_t cmd;
    spq_sts_t sts;

    // The controller sequences each word through the memory walk.
    spq_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // The datapath holds the entries, pointers and the output register.
    spq_dpath u_dpath (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tuser  (s_tuser),
        .s_tdata  (s_tdata),
        .m_tready (m_tready),
        .m_tvalid (m_tvalid),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .cmd      (cmd),
        .sts      (sts)
    );

endmodule
